// ----- rtl/acws_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acws_pkg
// Shared widths, codes and controller/datapath link types for the averaged
// crossing wind speed block.
// ----------------------------------------------------------------------------
package acws_pkg;

    localparam int SMP_W  = 10;  // ADC sample
    localparam int AVG_W  = 7;   // avg_count register
    localparam int LIM_W  = 10;  // cross_limit register
    localparam int COEF_W = 32;  // speed_gain / speed_offset
    localparam int OUT_W  = 16;  // result fields
    localparam int IDX_W  = 2;   // configuration index

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_AVG_COUNT    = 2'd0;
    localparam logic [IDX_W-1:0] REG_CROSS_LIMIT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_SPEED_GAIN   = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPEED_OFFSET = 2'd3;

    // crossing machine levels
    localparam logic [1:0] LVL_BELOW  = 2'd0;
    localparam logic [1:0] LVL_RISING = 2'd1;
    localparam logic [1:0] LVL_ABOVE  = 2'd2;

    // reset values of the configuration registers
    localparam logic [AVG_W-1:0]  AVG_COUNT_RST    = 7'd1;
    localparam logic [LIM_W-1:0]  CROSS_LIMIT_RST  = 10'd512;
    localparam logic [COEF_W-1:0] SPEED_GAIN_RST   = 32'sd1526695;
    localparam logic [COEF_W-1:0] SPEED_OFFSET_RST = -32'sd1748100;

    // controller -> datapath commands
    typedef struct packed {
        logic accept;    // take the offered request into the group sum
        logic div_step;  // one restoring division step
        logic feed;      // push the quotient through the crossing machine
        logic mul;       // count * gain
        logic add;       // + offset
        logic load_out;  // fill output register, clear run state
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic close;     // the next sample completes the group
        logic in_last;   // offered request carries last_sample
        logic last;      // request in flight carries last_sample
        logic out_free;  // output register can take a new result
    } stat_t;

endpackage : acws_pkg
`default_nettype wire

// ----- rtl/acws_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acws_dp
// Datapath: config registers, group accumulator, bit-serial divider,
// crossing machine, wind speed multiply/add/saturate and output register.
// ----------------------------------------------------------------------------
module acws_dp
    import acws_pkg::*;
#(
    parameter int MAX_GROUP = 64
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_wr,
    input  wire [IDX_W-1:0]    cfg_index,
    input  wire [COEF_W-1:0]   cfg_data,
    input  wire [SMP_W-1:0]    sample,
    input  wire                last_sample,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  wire                out_stall,
    output logic               out_valid,
    output logic [OUT_W-1:0]   wind_value,
    output logic [OUT_W-1:0]   crossing_total
);

    localparam int SUM_W  = $clog2(MAX_GROUP * 1023 + 1);
    localparam int PROD_W = OUT_W + 1 + COEF_W;
    localparam int ACC_W  = PROD_W + 1;

    // configuration
    logic [AVG_W-1:0]  avg_count_reg;
    logic [LIM_W-1:0]  cross_limit_reg;
    logic [COEF_W-1:0] speed_gain_reg;
    logic [COEF_W-1:0] speed_offset_reg;

    // run state
    logic [SUM_W-1:0]  sum_reg;
    logic [AVG_W-1:0]  fill_reg;
    logic [1:0]        level_reg;
    logic              first_reg;
    logic [OUT_W-1:0]  count_reg;
    logic              last_reg;
    logic              out_valid_reg;

    // payload
    logic [SUM_W-1:0]         quo_reg;
    logic [AVG_W-1:0]         rem_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [OUT_W-1:0]         wind_reg;
    logic [OUT_W-1:0]         total_reg;

    logic [AVG_W-1:0]  grp_n;
    logic [SUM_W-1:0]  sum_next;
    logic [AVG_W:0]    trial;
    logic              take;
    logic              ge;
    logic [OUT_W-1:0]  wind_next;

    // effective group size: 0 acts as 1, clamp at MAX_GROUP
    always_comb
    begin
        if (avg_count_reg == '0)
            grp_n = AVG_W'(1);
        else if (32'(avg_count_reg) > MAX_GROUP)
            grp_n = AVG_W'(MAX_GROUP);
        else
            grp_n = avg_count_reg;
    end

    assign sum_next = sum_reg + SUM_W'(sample);
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign take     = trial >= {1'b0, grp_n};
    assign ge       = quo_reg >= SUM_W'(cross_limit_reg);

    always_comb
    begin
        if (acc_reg[ACC_W-1])
            wind_next = '0;
        else if (|acc_reg[ACC_W-2:OUT_W+8])
            wind_next = '1;
        else
            wind_next = acc_reg[OUT_W+7:8];
    end

    assign stat.close    = (32'(fill_reg) + 1) >= 32'(grp_n);
    assign stat.in_last  = last_sample;
    assign stat.last     = last_reg;
    assign stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_count_reg    <= AVG_COUNT_RST;
            cross_limit_reg  <= CROSS_LIMIT_RST;
            speed_gain_reg   <= SPEED_GAIN_RST;
            speed_offset_reg <= SPEED_OFFSET_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_AVG_COUNT:    avg_count_reg    <= cfg_data[AVG_W-1:0];
                REG_CROSS_LIMIT:  cross_limit_reg  <= cfg_data[LIM_W-1:0];
                REG_SPEED_GAIN:   speed_gain_reg   <= cfg_data;
                REG_SPEED_OFFSET: speed_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            fill_reg      <= '0;
            level_reg     <= LVL_BELOW;
            first_reg     <= 1'b0;
            count_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                last_reg <= last_sample;
                if (stat.close)
                begin
                    sum_reg  <= '0;
                    fill_reg <= '0;
                end
                else
                begin
                    sum_reg  <= sum_next;
                    fill_reg <= fill_reg + AVG_W'(1);
                end
            end

            if (cmd.feed)
            begin
                if (!first_reg)
                begin
                    level_reg <= ge ? LVL_ABOVE : LVL_BELOW;
                    first_reg <= 1'b1;
                end
                else
                begin
                    case (level_reg)
                        LVL_RISING:
                        begin
                            level_reg <= LVL_ABOVE;
                            if (count_reg != '1)
                                count_reg <= count_reg + OUT_W'(1);
                        end
                        LVL_ABOVE:
                            if (!ge)
                                level_reg <= LVL_BELOW;
                        default:
                            level_reg <= ge ? LVL_RISING : LVL_BELOW;
                    endcase
                end
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
                sum_reg       <= '0;
                fill_reg      <= '0;
                level_reg     <= LVL_BELOW;
                first_reg     <= 1'b0;
                count_reg     <= '0;
                last_reg      <= 1'b0;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload path, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.accept && stat.close)
        begin
            quo_reg <= sum_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], take};
            rem_reg <= take ? AVG_W'(trial - {1'b0, grp_n}) : trial[AVG_W-1:0];
        end

        if (cmd.mul)
            prod_reg <= $signed({1'b0, count_reg}) * $signed(speed_gain_reg);
        if (cmd.add)
            acc_reg <= {prod_reg[PROD_W-1], prod_reg}
                     + {{(ACC_W-COEF_W){speed_offset_reg[COEF_W-1]}}, speed_offset_reg};
        if (cmd.load_out)
        begin
            wind_reg  <= wind_next;
            total_reg <= count_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign wind_value     = wind_reg;
    assign crossing_total = total_reg;

endmodule : acws_dp
`default_nettype wire

// ----- rtl/acws_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acws_ctrl
// Controller: sequences accept, divide, crossing update and result build.
// ----------------------------------------------------------------------------
module acws_ctrl
    import acws_pkg::*;
#(
    parameter int MAX_GROUP = 64
) (
    input  wire    clk,
    input  wire    rst_n,
    input  wire    in_valid,
    output logic   in_stall,
    input  stat_t  stat,
    output cmd_t   cmd
);

    localparam int SUM_W = $clog2(MAX_GROUP * 1023 + 1);
    localparam int CNT_W = $clog2(SUM_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_FEED = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.close)
                    begin
                        state_next = S_DIV;
                        cnt_next   = CNT_W'(SUM_W - 1);
                    end
                    else if (stat.in_last)
                        state_next = S_MUL;  // run ends on a partial group
                end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = S_FEED;
            end
            S_FEED:
            begin
                cmd.feed   = 1'b1;
                state_next = stat.last ? S_MUL : S_IDLE;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall = state_reg != S_IDLE;

endmodule : acws_ctrl
`default_nettype wire

// ----- rtl/averaged_crossing_wind_speed.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// averaged_crossing_wind_speed
// Averages groups of ADC samples, counts rising crossings of a limit and
// reports crossing count and derived wind speed at the end of each run.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   direction  handshake
//  -------   ----------------------------------------  ---------  ----------------
//  input     in_valid in_stall sample last_sample      in         valid / stall
//  output    out_valid out_stall wind_value            out        valid / stall
//            crossing_total
//  config    cfg_valid cfg_ready cfg_index cfg_data    in         valid / ready
//
//  A sample that does not close a group is accepted without a stall. One that
//  closes a group stalls input while the one-bit-a-cycle restoring divider forms
//  SUM_W quotient bits (SUM_W = clog2(MAX_GROUP*1023+1), 16 at the default);
//  the quotient then feeds the crossing machine. A run's last sample adds
//  multiply, add and a saturating load, which waits while out_stall holds output.
//  Reset is asynchronous, active low; configuration returns to its defaults.
//  Input requests are stalled while a group divides or a result is built;
//  the build waits in its final step until the output register is free.
//
module averaged_crossing_wind_speed
    import acws_pkg::*;
#(
    parameter int MAX_GROUP = 64
) (
    input  wire                clk,
    input  wire                rst_n,
    // configuration
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire [IDX_W-1:0]    cfg_index,
    input  wire [COEF_W-1:0]   cfg_data,
    // sample requests
    input  wire                in_valid,
    output logic               in_stall,
    input  wire [SMP_W-1:0]    sample,
    input  wire                last_sample,
    // results
    output logic               out_valid,
    input  wire                out_stall,
    output logic [OUT_W-1:0]   wind_value,
    output logic [OUT_W-1:0]   crossing_total
);

    cmd_t  cmd;
    stat_t stat;

    // registers are always writable; the user must write only while idle, the block does not enforce this
    assign cfg_ready = 1'b1;

    acws_ctrl #(
        .MAX_GROUP (MAX_GROUP)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    acws_dp #(
        .MAX_GROUP (MAX_GROUP)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample         (sample),
        .last_sample    (last_sample),
        .cmd            (cmd),
        .stat           (stat),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .wind_value     (wind_value),
        .crossing_total (crossing_total)
    );

endmodule : averaged_crossing_wind_speed
`default_nettype wire

// ----- rtl/acws_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acws_checker
// Port-level checks for the averaged crossing wind speed block.
// ----------------------------------------------------------------------------
module acws_checker
    import acws_pkg::*;
(
    input wire               clk,
    input wire               rst_n,
    input wire               in_valid,
    input wire               in_stall,
    input wire               last_sample,
    input wire               out_valid,
    input wire               out_stall,
    input wire [OUT_W-1:0]   wind_value,
    input wire [OUT_W-1:0]   crossing_total
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(wind_value)
                                   && $stable(crossing_total))
        else $error("result changed while stalled");

    // the run-end request always occupies the block
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_sample |=> in_stall)
        else $error("last request did not start result build");

    // results are only loaded from the busy result stage
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without result build");

    a_back_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid || $past(in_stall))
        else $error("back-to-back result without result build");

endmodule : acws_checker

bind averaged_crossing_wind_speed acws_checker u_acws_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .last_sample    (last_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .wind_value     (wind_value),
    .crossing_total (crossing_total)
);
`default_nettype wire
